/* rtl/mcit_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcit_pkg
// Shared constants, codes and types of the multi-channel interval timer.
// ----------------------------------------------------------------------------
package mcit_pkg;

  localparam int NUM_CHANNELS = 8;
  localparam int CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int MAX_OUT      = 8;
  localparam int REP_W        = $clog2(MAX_OUT + 1);

  localparam int ACTION_W = 3;
  localparam int CHAN_W   = 3;
  localparam int PERIOD_W = 32;
  localparam int STATUS_W = 2;
  localparam int TICK_W   = 32;

  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 40;

  localparam logic [ACTION_W-1:0] ACT_TICK    = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_ALLOC   = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_START   = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_STOP    = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_RESET   = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_RELEASE = 3'd5;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_NO_FREE  = 2'd1,
    ST_BAD_CHAN = 2'd2
  } status_t;

  localparam logic KIND_ACK    = 1'b0;
  localparam logic KIND_EXPIRY = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [CHAN_W-1:0] chan;
    status_t           status;
  } result_t;

endpackage

/* rtl/multi_channel_interval_timer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_channel_interval_timer_top
// Bank of one-shot or periodic countdown channels with a small sequencer.
// ----------------------------------------------------------------------------
// A tick sweeps the bank with one shared decrement and zero test that visits
// one channel per cycle unless an expiry must be sent while the result register
// is held, and each expiry is held one slot back so the final result can carry
// tlast. Allocate searches for the lowest free channel with the same channel
// pointer. The sweep and the final result wait whenever the result register is
// still held by the downstream side. A request is taken only while the
// sequencer is idle; results leave through a register, so the next request can
// be taken while the last result is still waiting.
module multi_channel_interval_timer_top
  import mcit_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // action[2:0], channel[5:3], period_ms[37:6], periodic[38], zero[39]
  input  logic [S_TDATA_W-1:0] s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // result_channel[2:0], status[4:3], tick_count[36:5], zero[39:37]
  output logic [M_TDATA_W-1:0] m_tdata,
  // kind[0]
  output logic                 m_tuser,
  output logic                 m_tlast
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SWEEP = 5'b00010,
    S_FIND  = 5'b00100,
    S_CMD   = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t                state;

  logic [NUM_CHANNELS-1:0] allocated;
  logic [NUM_CHANNELS-1:0] enabled;
  logic [NUM_CHANNELS-1:0] repeat_mode;
  logic [PERIOD_W-1:0]     reload_value [NUM_CHANNELS];
  logic [PERIOD_W-1:0]     remaining    [NUM_CHANNELS];
  logic [TICK_W-1:0]       ticks_seen;

  logic [ACTION_W-1:0] action_q;
  logic [CHAN_W-1:0]   chan_q;
  logic [PERIOD_W-1:0] period_q;
  logic                periodic_q;
  logic                bad_q;
  logic [CH_IDX_W-1:0] idx;
  logic [REP_W-1:0]    n_rep;
  result_t             pend;
  logic                pend_valid;

  result_t             m_res;
  logic [TICK_W-1:0]   m_ticks;

  logic                in_accept;
  logic [ACTION_W-1:0] in_action;
  logic [CHAN_W-1:0]   in_chan;
  logic [PERIOD_W-1:0] in_period;
  logic                in_periodic;
  logic                out_free;
  logic [PERIOD_W-1:0] rem_dec;
  logic                active;
  logic                expire;
  logic                report;
  logic                sweep_stall;
  logic                m_load;
  logic                last_idx;
  logic [CHAN_W-1:0]   idx_chan;

  assign in_action   = s_tdata[2:0];
  assign in_chan     = s_tdata[5:3];
  assign in_period   = s_tdata[37:6];
  assign in_periodic = s_tdata[38];

  assign s_tready  = (state == S_IDLE);
  assign in_accept = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  // shared decrement and zero test on the channel under the pointer
  assign rem_dec     = remaining[idx] - PERIOD_W'(1);
  assign active      = allocated[idx] && enabled[idx];
  assign expire      = active && (rem_dec == '0);
  assign report      = expire && (n_rep < REP_W'(MAX_OUT));
  assign sweep_stall = report && pend_valid && !out_free;
  assign m_load      = ((state == S_SWEEP) && report && pend_valid && out_free) ||
                       ((state == S_EMIT) && out_free);
  assign last_idx    = (idx == CH_IDX_W'(NUM_CHANNELS - 1));
  assign idx_chan    = CHAN_W'(idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      m_tvalid   <= 1'b0;
      allocated  <= '0;
      enabled    <= '0;
      ticks_seen <= '0;
      pend_valid <= 1'b0;
    end else begin
      m_tvalid <= m_load || (m_tvalid && !m_tready);
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            action_q   <= in_action;
            chan_q     <= in_chan;
            period_q   <= in_period;
            periodic_q <= in_periodic;
            bad_q      <= (32'(in_chan) >= 32'(NUM_CHANNELS));
            priority case (in_action)
              ACT_TICK: begin
                ticks_seen <= ticks_seen + TICK_W'(1);
                idx        <= '0;
                n_rep      <= '0;
                pend_valid <= 1'b0;
                state      <= S_SWEEP;
              end
              ACT_ALLOC: begin
                idx   <= '0;
                state <= S_FIND;
              end
              ACT_START, ACT_STOP, ACT_RESET, ACT_RELEASE: begin
                idx   <= CH_IDX_W'(in_chan);
                state <= S_CMD;
              end
              default: begin
                pend  <= '{kind: KIND_ACK, chan: in_chan, status: ST_BAD_CHAN};
                state <= S_EMIT;
              end
            endcase
          end
        end
        S_CMD: begin
          if (bad_q || !allocated[idx]) begin
            pend <= '{kind: KIND_ACK, chan: chan_q, status: ST_BAD_CHAN};
          end else begin
            priority case (action_q)
              ACT_START: begin
                remaining[idx] <= reload_value[idx];
                enabled[idx]   <= 1'b1;
              end
              ACT_STOP: begin
                enabled[idx] <= 1'b0;
              end
              ACT_RESET: begin
                enabled[idx]   <= 1'b0;
                remaining[idx] <= reload_value[idx];
              end
              default: begin
                allocated[idx]    <= 1'b0;
                enabled[idx]      <= 1'b0;
                repeat_mode[idx]  <= 1'b0;
                reload_value[idx] <= '0;
                remaining[idx]    <= '0;
              end
            endcase
            pend <= '{kind: KIND_ACK, chan: chan_q, status: ST_OK};
          end
          state <= S_EMIT;
        end
        S_FIND: begin
          if (!allocated[idx]) begin
            allocated[idx]    <= 1'b1;
            enabled[idx]      <= 1'b0;
            repeat_mode[idx]  <= periodic_q;
            reload_value[idx] <= period_q;
            remaining[idx]    <= period_q;
            pend  <= '{kind: KIND_ACK, chan: idx_chan, status: ST_OK};
            state <= S_EMIT;
          end else if (last_idx) begin
            pend  <= '{kind: KIND_ACK, chan: '0, status: ST_NO_FREE};
            state <= S_EMIT;
          end else begin
            idx <= idx + CH_IDX_W'(1);
          end
        end
        S_SWEEP: begin
          if (!sweep_stall) begin
            if (active) begin
              if (expire) begin
                remaining[idx] <= reload_value[idx];
                if (!repeat_mode[idx]) begin
                  enabled[idx] <= 1'b0;
                end
              end else begin
                remaining[idx] <= rem_dec;
              end
            end
            if (report) begin
              // held expiry is not the final one, send it on
              if (pend_valid) begin
                m_res    <= pend;
                m_ticks  <= ticks_seen;
                m_tlast  <= 1'b0;
              end
              pend       <= '{kind: KIND_EXPIRY, chan: idx_chan, status: ST_OK};
              pend_valid <= 1'b1;
              n_rep      <= n_rep + REP_W'(1);
            end
            if (last_idx) begin
              if (!pend_valid && !report) begin
                pend <= '{kind: KIND_ACK, chan: '0, status: ST_OK};
              end
              state <= S_EMIT;
            end else begin
              idx <= idx + CH_IDX_W'(1);
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            m_res      <= pend;
            m_ticks    <= ticks_seen;
            m_tlast    <= 1'b1;
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {3'b000, m_ticks, m_res.status, m_res.chan};
  assign m_tuser = m_res.kind;

  // a running channel is always an allocated one
  assert property (@(posedge clk) disable iff (rst)
    (enabled & ~allocated) == '0)
    else $error("enabled channel not allocated");

  // the tick counter moves only on an accepted tick
  assert property (@(posedge clk) disable iff (rst)
    !(in_accept && (in_action == ACT_TICK)) |=> $stable(ticks_seen))
    else $error("tick counter moved without a tick");

  // no expiry is left behind once the sequencer is idle
  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !pend_valid)
    else $error("pending expiry while idle");

  // never more expiries reported than the limit
  assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP) |-> (n_rep <= REP_W'(MAX_OUT)))
    else $error("expiry report count overflow");

endmodule

/* verif/tb_multi_channel_interval_timer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multi_channel_interval_timer_top
// Self-checking bench for the timer bank. A short table of directed requests
// (reset state, full bank, bad channels, simultaneous expiries) is followed by
// random request streams, undefined actions among them. A behavioural model of the channel bank
// predicts every result, and each one is compared on arrival, with random
// stalls on both stream sides.
// ----------------------------------------------------------------------------
module tb_multi_channel_interval_timer_top;
  import mcit_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_UNDEF_LO = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_UNDEF_HI = 3'd7;
  localparam int RAND_ITEMS  = 256;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic              kind;
    logic [CHAN_W-1:0] chan;
    status_t           status;
    logic [TICK_W-1:0] ticks;
    logic              last;
  } timer_result_t;

  typedef struct {
    logic [ACTION_W-1:0] act;
    logic [CHAN_W-1:0]   ch;
    logic [PERIOD_W-1:0] period;
    logic                per;
    bit                  typed;
    logic                kind;
    logic [CHAN_W-1:0]   chan;
    status_t             status;
    logic [TICK_W-1:0]   ticks;
  } stim_row_t;

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata  = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b1;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tuser;
  logic                 m_tlast;

  // channel bank model
  bit                  ch_allocated [NUM_CHANNELS];
  bit                  ch_enabled   [NUM_CHANNELS];
  bit                  ch_periodic  [NUM_CHANNELS];
  logic [PERIOD_W-1:0] ch_reload    [NUM_CHANNELS];
  logic [PERIOD_W-1:0] ch_remaining [NUM_CHANNELS];
  logic [TICK_W-1:0]   tick_total;

  timer_result_t pending_results[$];
  timer_result_t want;
  stim_row_t     script[$];
  int            live[$];
  int            errors    = 0;
  int            cycles    = 0;
  int unsigned   stall_cnt = 0;
  bit            idle_on   = 1'b0;

  multi_channel_interval_timer_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[multi_channel_interval_timer_top] ERROR");
      $finish;
    end
  end

  // downstream stalls come in random bursts
  always @(posedge clk) begin
    if (stall_cnt != 0) begin
      m_tready  <= 1'b0;
      stall_cnt <= stall_cnt - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      m_tready  <= 1'b0;
      stall_cnt <= $urandom_range(0, 3);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: tdata %h kind %0d last %0d",
               m_tdata, m_tuser, m_tlast);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (m_tuser !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, m_tuser);
          errors++;
        end
        if (m_tdata[2:0] !== want.chan) begin
          $error("result_channel: expected %0d, got %0d", want.chan, m_tdata[2:0]);
          errors++;
        end
        if (m_tdata[4:3] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_tdata[4:3]);
          errors++;
        end
        if (m_tdata[36:5] !== want.ticks) begin
          $error("tick_count: expected %0d, got %0d", want.ticks, m_tdata[36:5]);
          errors++;
        end
        if (m_tlast !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, m_tlast);
          errors++;
        end
      end
    end
  end

  function automatic void push_result(input logic kind, input logic [CHAN_W-1:0] chan,
                                      input status_t status, input logic last);
    pending_results.push_back('{kind, chan, status, tick_total, last});
  endfunction

  function automatic void predict_request(input logic [ACTION_W-1:0] act,
                                          input logic [CHAN_W-1:0]   ch,
                                          input logic [PERIOD_W-1:0] period,
                                          input logic                per);
    int expired[$];
    int slot;
    slot = -1;
    case (act)
      ACT_TICK: begin
        tick_total = tick_total + 1;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          if (ch_allocated[i] && ch_enabled[i]) begin
            ch_remaining[i] = ch_remaining[i] - 1;
            if (ch_remaining[i] == 0) begin
              if (!ch_periodic[i]) ch_enabled[i] = 1'b0;
              ch_remaining[i] = ch_reload[i];
              // expiries past the report limit still reload silently
              if (expired.size() < MAX_OUT) expired.push_back(i);
            end
          end
        end
        if (expired.size() == 0) push_result(KIND_ACK, '0, ST_OK, 1'b1);
        foreach (expired[k])
          push_result(KIND_EXPIRY, CHAN_W'(expired[k]), ST_OK, k == expired.size() - 1);
      end
      ACT_ALLOC: begin
        for (int i = 0; i < NUM_CHANNELS; i++)
          if (!ch_allocated[i] && slot < 0) slot = i;
        if (slot >= 0) begin
          ch_allocated[slot] = 1'b1;
          ch_enabled[slot]   = 1'b0;
          ch_periodic[slot]  = per;
          ch_reload[slot]    = period;
          ch_remaining[slot] = period;
          push_result(KIND_ACK, CHAN_W'(slot), ST_OK, 1'b1);
        end else begin
          push_result(KIND_ACK, '0, ST_NO_FREE, 1'b1);
        end
      end
      ACT_START, ACT_STOP, ACT_RESET, ACT_RELEASE: begin
        if (!ch_allocated[ch]) begin
          push_result(KIND_ACK, ch, ST_BAD_CHAN, 1'b1);
        end else begin
          case (act)
            ACT_START: begin
              ch_remaining[ch] = ch_reload[ch];
              ch_enabled[ch]   = 1'b1;
            end
            ACT_STOP: ch_enabled[ch] = 1'b0;
            ACT_RESET: begin
              ch_enabled[ch]   = 1'b0;
              ch_remaining[ch] = ch_reload[ch];
            end
            default: begin
              ch_allocated[ch] = 1'b0;
              ch_enabled[ch]   = 1'b0;
              ch_periodic[ch]  = 1'b0;
              ch_reload[ch]    = '0;
              ch_remaining[ch] = '0;
            end
          endcase
          push_result(KIND_ACK, ch, ST_OK, 1'b1);
        end
      end
      default: push_result(KIND_ACK, ch, ST_BAD_CHAN, 1'b1);
    endcase
  endfunction

  task automatic send_request(input logic [ACTION_W-1:0] act, input logic [CHAN_W-1:0] ch,
                              input logic [PERIOD_W-1:0] period, input logic per);
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, per, period, ch, act};
    do @(posedge clk); while (!s_tready);
    predict_request(act, ch, period, per);
  endtask

  task automatic take_gap();
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  initial begin
    logic [ACTION_W-1:0] act;
    logic [CHAN_W-1:0]   ch;
    logic [PERIOD_W-1:0] period;
    logic                per;
    int unsigned         pick;
    int unsigned         sel;

    for (int i = 0; i < NUM_CHANNELS; i++) begin
      ch_allocated[i] = 1'b0;
      ch_enabled[i]   = 1'b0;
      ch_periodic[i]  = 1'b0;
      ch_reload[i]    = '0;
      ch_remaining[i] = '0;
    end
    tick_total = '0;

    // idle bank, bad and undefined requests
    script.push_back('{ACT_TICK,     3'd0, 32'd0, 1'b0, 1'b1, KIND_ACK, 3'd0, ST_OK, 32'd1});
    script.push_back('{ACT_START,    3'd3, 32'd0, 1'b0, 1'b1, KIND_ACK, 3'd3, ST_BAD_CHAN,
                       32'd1});
    script.push_back('{ACT_UNDEF_HI, 3'd7, 32'hFFFFFFFF, 1'b1, 1'b1, KIND_ACK, 3'd7,
                       ST_BAD_CHAN, 32'd1});
    // fill the bank, period zero and full-scale period among them
    script.push_back('{ACT_ALLOC, 3'd0, 32'd2, 1'b1, 1'b1, KIND_ACK, 3'd0, ST_OK, 32'd1});
    script.push_back('{ACT_ALLOC, 3'd0, 32'd0, 1'b0, 1'b1, KIND_ACK, 3'd1, ST_OK, 32'd1});
    script.push_back('{ACT_ALLOC, 3'd0, 32'hFFFFFFFF, 1'b1, 1'b1, KIND_ACK, 3'd2, ST_OK,
                       32'd1});
    script.push_back('{ACT_ALLOC, 3'd0, 32'd1, 1'b0, 1'b1, KIND_ACK, 3'd3, ST_OK, 32'd1});
    script.push_back('{ACT_ALLOC, 3'd0, 32'd1, 1'b1, 1'b1, KIND_ACK, 3'd4, ST_OK, 32'd1});
    script.push_back('{ACT_ALLOC, 3'd0, 32'd1, 1'b0, 1'b1, KIND_ACK, 3'd5, ST_OK, 32'd1});
    script.push_back('{ACT_ALLOC, 3'd0, 32'd3, 1'b1, 1'b1, KIND_ACK, 3'd6, ST_OK, 32'd1});
    script.push_back('{ACT_ALLOC, 3'd0, 32'd1, 1'b1, 1'b1, KIND_ACK, 3'd7, ST_OK, 32'd1});
    script.push_back('{ACT_ALLOC, 3'd0, 32'd5, 1'b1, 1'b1, KIND_ACK, 3'd0, ST_NO_FREE, 32'd1});
    script.push_back('{ACT_START, 3'd0, 32'd0, 1'b0, 1'b1, KIND_ACK, 3'd0, ST_OK, 32'd1});
    script.push_back('{ACT_START, 3'd1, 32'd0, 1'b0, 1'b1, KIND_ACK, 3'd1, ST_OK, 32'd1});
    script.push_back('{ACT_START, 3'd3, 32'd0, 1'b0, 1'b1, KIND_ACK, 3'd3, ST_OK, 32'd1});
    script.push_back('{ACT_START, 3'd4, 32'd0, 1'b0, 1'b1, KIND_ACK, 3'd4, ST_OK, 32'd1});
    script.push_back('{ACT_START, 3'd5, 32'd0, 1'b0, 1'b1, KIND_ACK, 3'd5, ST_OK, 32'd1});
    script.push_back('{ACT_START, 3'd6, 32'd0, 1'b0, 1'b1, KIND_ACK, 3'd6, ST_OK, 32'd1});
    script.push_back('{ACT_START, 3'd7, 32'd0, 1'b0, 1'b1, KIND_ACK, 3'd7, ST_OK, 32'd1});
    // several channels expiring on the same tick
    script.push_back('{ACT_TICK, 3'd0, 32'd0, 1'b0, 1'b0, KIND_ACK, 3'd0, ST_OK, 32'd0});
    script.push_back('{ACT_TICK, 3'd0, 32'd0, 1'b0, 1'b0, KIND_ACK, 3'd0, ST_OK, 32'd0});
    script.push_back('{ACT_STOP,    3'd4, 32'd0, 1'b0, 1'b1, KIND_ACK, 3'd4, ST_OK, 32'd3});
    script.push_back('{ACT_RESET,   3'd5, 32'd0, 1'b0, 1'b1, KIND_ACK, 3'd5, ST_OK, 32'd3});
    script.push_back('{ACT_RELEASE, 3'd6, 32'd0, 1'b0, 1'b1, KIND_ACK, 3'd6, ST_OK, 32'd3});
    script.push_back('{ACT_RELEASE, 3'd6, 32'd0, 1'b0, 1'b1, KIND_ACK, 3'd6, ST_BAD_CHAN,
                       32'd3});

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    idle_on = 1'b1;
    foreach (script[i]) begin
      send_request(script[i].act, script[i].ch, script[i].period, script[i].per);
      if (script[i].typed) begin
        void'(pending_results.pop_back());
        pending_results.push_back('{script[i].kind, script[i].chan, script[i].status,
                                    script[i].ticks, 1'b1});
      end
      take_gap();
    end

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 20 == 0) idle_on = ($urandom_range(0, 3) != 0);
      if (n >= RAND_ITEMS - 40) idle_on = 1'b0;

      // mostly requests aimed at live channels
      ch = CHAN_W'($urandom_range(0, NUM_CHANNELS - 1));
      live.delete();
      for (int i = 0; i < NUM_CHANNELS; i++)
        if (ch_allocated[i]) live.push_back(i);
      if (live.size() != 0 && $urandom_range(0, 6) != 0)
        ch = CHAN_W'(live[$urandom_range(0, live.size() - 1)]);

      pick = $urandom_range(0, 99);
      if (pick < 35)      act = ACT_TICK;
      else if (pick < 50) act = ACT_ALLOC;
      else if (pick < 65) act = ACT_START;
      else if (pick < 73) act = ACT_STOP;
      else if (pick < 80) act = ACT_RESET;
      else if (pick < 92) act = ACT_RELEASE;
      else                act = ($urandom_range(0, 1) != 0) ? ACT_UNDEF_HI : ACT_UNDEF_LO;

      sel = $urandom_range(0, 9);
      if (sel < 6)       period = $urandom_range(1, 5);
      else if (sel == 6) period = '0;
      else if (sel == 7) period = $urandom_range(6, 20);
      else               period = $urandom();
      per = 1'($urandom_range(0, 1));

      send_request(act, ch, period, per);
      take_gap();
    end
    s_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (errors == 0 && pending_results.size() == 0) begin
      $display("[multi_channel_interval_timer_top] OK");
    end else begin
      $display("[multi_channel_interval_timer_top] ERROR");
    end
    $finish;
  end

endmodule
